// ===== rtl/miller_rabin_round_assert.svh =====
// ---------------------------------------------------------------------------
// Miller-Rabin round assertion macros
// Clocked property checks; compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MILLER_RABIN_ROUND_ASSERT_SVH
`define MILLER_RABIN_ROUND_ASSERT_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define MRR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("miller_rabin_round: same-cycle check failed");

// ante implies cons in the next cycle
`define MRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("miller_rabin_round: next-cycle check failed");

`else

`define MRR_ASSERT_SAME(label, clk, rst, ante, cons)
`define MRR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/mrr_pkg.sv =====
// ---------------------------------------------------------------------------
// Miller-Rabin round package
// Widths, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package mrr_pkg;

  localparam int FIELD_W = 63;
  localparam int WIDTH   = 63;
  localparam int CW      = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] val_t;
  typedef logic [CW-1:0]    cnt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_SPLIT,
    S_POW_TEST,
    S_MUL_R,
    S_MUL_B,
    S_SQ_TEST,
    S_MUL_S,
    S_DONE
  } state_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_RB,   // result * base
    MUL_BB,   // base * base
    MUL_XX    // result * result
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     red_step;
    logic     split_step;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     wr_result;
    logic     wr_base;
    logic     e_shift;
    logic     wr_sq;
    logic     set_verdict;
    logic     verdict_val;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic is_two;
    logic bad;
    logic red_last;
    logic d_odd;
    logic mul_done;
    logic e_zero;
    logic e_lsb;
    logic k_zero;
    logic res_one;
    logic nontrivial;
  } stat_t;

endpackage

// ===== rtl/mrr_dp.sv =====
// ---------------------------------------------------------------------------
// Miller-Rabin round datapath
// Operand registers, bit-serial witness reduction, exponent split and a
// shift-add modular multiplier that retires one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module mrr_dp (
  input  logic                            clk,
  input  logic [mrr_pkg::FIELD_W-1:0]     candidate,
  input  logic [mrr_pkg::FIELD_W-1:0]     witness,
  input  mrr_pkg::cmd_t                   cmd,
  output mrr_pkg::stat_t                  stat,
  output logic                            probably_prime
);

  mrr_pkg::val_t n;
  mrr_pkg::val_t nm1;
  mrr_pkg::val_t wit;
  mrr_pkg::val_t base;
  mrr_pkg::val_t e;
  mrr_pkg::val_t result;
  mrr_pkg::val_t acc;
  mrr_pkg::val_t addend;
  mrr_pkg::val_t y;
  mrr_pkg::cnt_t k;
  mrr_pkg::cnt_t red_cnt;
  logic          verdict;

  logic [mrr_pkg::WIDTH:0] n_ext;
  logic [mrr_pkg::WIDTH:0] red_shift;
  mrr_pkg::val_t           red_next;
  logic [mrr_pkg::WIDTH:0] sum;
  mrr_pkg::val_t           acc_next;
  logic [mrr_pkg::WIDTH:0] dbl;
  mrr_pkg::val_t           addend_next;
  mrr_pkg::val_t           op_a;
  mrr_pkg::val_t           op_b;

  assign n_ext = {1'b0, n};

  // witness mod n, one witness bit per cycle, MSB first
  assign red_shift = {base, wit[mrr_pkg::WIDTH-1]};
  always_comb begin
    if (red_shift >= n_ext) begin
      red_next = mrr_pkg::WIDTH'(red_shift - n_ext);
    end else begin
      red_next = red_shift[mrr_pkg::WIDTH-1:0];
    end
  end

  // one shift-add step of the modular multiplier
  assign sum = {1'b0, acc} + {1'b0, addend};
  assign dbl = {addend, 1'b0};
  always_comb begin
    acc_next = acc;
    if (y[0]) begin
      if (sum >= n_ext) begin
        acc_next = mrr_pkg::WIDTH'(sum - n_ext);
      end else begin
        acc_next = sum[mrr_pkg::WIDTH-1:0];
      end
    end
    if (dbl >= n_ext) begin
      addend_next = mrr_pkg::WIDTH'(dbl - n_ext);
    end else begin
      addend_next = dbl[mrr_pkg::WIDTH-1:0];
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      mrr_pkg::MUL_RB: begin
        op_a = result;
        op_b = base;
      end
      mrr_pkg::MUL_BB: begin
        op_a = base;
        op_b = base;
      end
      mrr_pkg::MUL_XX: begin
        op_a = result;
        op_b = result;
      end
      default: begin
        op_a = result;
        op_b = result;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= candidate[mrr_pkg::WIDTH-1:0];
      nm1     <= candidate[mrr_pkg::WIDTH-1:0] - mrr_pkg::WIDTH'(1);
      e       <= candidate[mrr_pkg::WIDTH-1:0] - mrr_pkg::WIDTH'(1);
      wit     <= witness[mrr_pkg::WIDTH-1:0];
      base    <= '0;
      result  <= mrr_pkg::WIDTH'(1);
      k       <= '0;
      red_cnt <= mrr_pkg::CW'(mrr_pkg::WIDTH - 1);
    end
    if (cmd.red_step) begin
      base    <= red_next;
      wit     <= {wit[mrr_pkg::WIDTH-2:0], 1'b0};
      red_cnt <= red_cnt - mrr_pkg::CW'(1);
    end
    if (cmd.split_step) begin
      e <= {1'b0, e[mrr_pkg::WIDTH-1:1]};
      k <= k + mrr_pkg::CW'(1);
    end
    if (cmd.mul_start) begin
      acc    <= '0;
      addend <= op_a;
      y      <= op_b;
    end else if (cmd.mul_step) begin
      acc    <= acc_next;
      addend <= addend_next;
      y      <= {1'b0, y[mrr_pkg::WIDTH-1:1]};
    end
    if (cmd.wr_result) begin
      result <= acc;
    end
    if (cmd.wr_base) begin
      base <= acc;
    end
    if (cmd.e_shift) begin
      e <= {1'b0, e[mrr_pkg::WIDTH-1:1]};
    end
    if (cmd.wr_sq) begin
      result <= acc;
      k      <= k - mrr_pkg::CW'(1);
    end
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict_val;
    end
    if (cmd.out_load) begin
      probably_prime <= verdict;
    end
  end

  assign stat.is_two     = (n == mrr_pkg::WIDTH'(2));
  assign stat.bad        = (n[mrr_pkg::WIDTH-1:1] == '0) || !n[0];
  assign stat.red_last   = (red_cnt == '0);
  assign stat.d_odd      = e[0];
  assign stat.mul_done   = (y == '0);
  assign stat.e_zero     = (e == '0);
  assign stat.e_lsb      = e[0];
  assign stat.k_zero     = (k == '0);
  assign stat.res_one    = (result == mrr_pkg::WIDTH'(1));
  assign stat.nontrivial = (acc == mrr_pkg::WIDTH'(1)) &&
                           (result != mrr_pkg::WIDTH'(1)) && (result != nm1);

endmodule

// ===== rtl/mrr_ctrl.sv =====
// ---------------------------------------------------------------------------
// Miller-Rabin round controller
// Sequences special-case check, reduction, exponent split, modular power,
// the squaring chain and the result handoff.
// ---------------------------------------------------------------------------
module mrr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mrr_pkg::stat_t stat,
  output mrr_pkg::cmd_t  cmd
);

  mrr_pkg::state_t state;
  mrr_pkg::state_t state_next;
  logic            out_valid_next;
  logic            slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mrr_pkg::S_IDLE: begin
        if (in_valid) state_next = mrr_pkg::S_CHECK;
      end
      mrr_pkg::S_CHECK: begin
        if (stat.is_two || stat.bad) begin
          state_next = mrr_pkg::S_DONE;
        end else begin
          state_next = mrr_pkg::S_REDUCE;
        end
      end
      mrr_pkg::S_REDUCE: begin
        if (stat.red_last) state_next = mrr_pkg::S_SPLIT;
      end
      mrr_pkg::S_SPLIT: begin
        if (stat.d_odd) state_next = mrr_pkg::S_POW_TEST;
      end
      mrr_pkg::S_POW_TEST: begin
        if (stat.e_zero) begin
          state_next = mrr_pkg::S_SQ_TEST;
        end else if (stat.e_lsb) begin
          state_next = mrr_pkg::S_MUL_R;
        end else begin
          state_next = mrr_pkg::S_MUL_B;
        end
      end
      mrr_pkg::S_MUL_R: begin
        if (stat.mul_done) state_next = mrr_pkg::S_MUL_B;
      end
      mrr_pkg::S_MUL_B: begin
        if (stat.mul_done) state_next = mrr_pkg::S_POW_TEST;
      end
      mrr_pkg::S_SQ_TEST: begin
        if (stat.k_zero) begin
          state_next = mrr_pkg::S_DONE;
        end else begin
          state_next = mrr_pkg::S_MUL_S;
        end
      end
      mrr_pkg::S_MUL_S: begin
        if (stat.mul_done) begin
          if (stat.nontrivial) begin
            state_next = mrr_pkg::S_DONE;
          end else begin
            state_next = mrr_pkg::S_SQ_TEST;
          end
        end
      end
      mrr_pkg::S_DONE: begin
        if (slot_free) state_next = mrr_pkg::S_IDLE;
      end
      default: state_next = mrr_pkg::S_IDLE;
    endcase
  end

  assign in_stall = (state != mrr_pkg::S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mrr_pkg::MUL_RB;
    unique case (state)
      mrr_pkg::S_IDLE: begin
        cmd.load = in_valid;
      end
      mrr_pkg::S_CHECK: begin
        if (stat.is_two) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict_val = 1'b1;
        end else if (stat.bad) begin
          cmd.set_verdict = 1'b1;
        end
      end
      mrr_pkg::S_REDUCE: begin
        cmd.red_step = 1'b1;
      end
      mrr_pkg::S_SPLIT: begin
        cmd.split_step = !stat.d_odd;
      end
      mrr_pkg::S_POW_TEST: begin
        if (!stat.e_zero) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = stat.e_lsb ? mrr_pkg::MUL_RB : mrr_pkg::MUL_BB;
        end
      end
      mrr_pkg::S_MUL_R: begin
        if (!stat.mul_done) begin
          cmd.mul_step = 1'b1;
        end else begin
          cmd.wr_result = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mrr_pkg::MUL_BB;
        end
      end
      mrr_pkg::S_MUL_B: begin
        if (!stat.mul_done) begin
          cmd.mul_step = 1'b1;
        end else begin
          cmd.wr_base = 1'b1;
          cmd.e_shift = 1'b1;
        end
      end
      mrr_pkg::S_SQ_TEST: begin
        if (stat.k_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict_val = stat.res_one;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mrr_pkg::MUL_XX;
        end
      end
      mrr_pkg::S_MUL_S: begin
        if (!stat.mul_done) begin
          cmd.mul_step = 1'b1;
        end else if (stat.nontrivial) begin
          cmd.set_verdict = 1'b1;
        end else begin
          cmd.wr_sq = 1'b1;
        end
      end
      mrr_pkg::S_DONE: begin
        cmd.out_load = slot_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/miller_rabin_round.sv =====
// ---------------------------------------------------------------------------
// Miller-Rabin round
// One round of the Miller-Rabin probable-prime test on a candidate/witness.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_stall with candidate and witness; one item is
// taken whenever the block is idle. Output channel: out_valid/out_stall with
// probably_prime, one item per input item, held in an output register.
// Candidate 2, below 2 or even: the verdict is set in the check state.
// Otherwise the item passes check, reduction and split, the split shifting
// once per trailing zero of n-1, then per bit of d a test state plus one
// or two modular multiplications, and per squaring a test state plus one.
// Each multiplication steps once per significant bit of its multiplier
// operand: the shift-add multiplier retires one bit per cycle.
// One item is in work at a time; a new item is taken while the previous
// result still waits in the output register, and a finished result waits
// in the controller until that register is free.
// A stalled output holds its value. Reset clears the controller and drops
// any item in work or waiting.
// ---------------------------------------------------------------------------
`include "miller_rabin_round_assert.svh"

module miller_rabin_round (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mrr_pkg::FIELD_W-1:0] candidate,
  input  logic [mrr_pkg::FIELD_W-1:0] witness,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        probably_prime
);

  mrr_pkg::cmd_t  cmd;
  mrr_pkg::stat_t stat;

  mrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrr_dp u_dp (
    .clk            (clk),
    .candidate      (candidate),
    .witness        (witness),
    .cmd            (cmd),
    .stat           (stat),
    .probably_prime (probably_prime)
  );

  `MRR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `MRR_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || !out_stall)
  `MRR_ASSERT_NEXT(a_idle_after_deliver, clk, rst, cmd.out_load, !in_stall && out_valid)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin round testbench
// Feeds candidate/witness items to the round, predicts each verdict with an
// independent shift-add modular arithmetic model and checks every
// probably_prime result in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 77;
  localparam int IDLE_PCT       = 31;
  localparam int CALM_FIRST     = 45;
  localparam int CALM_LAST      = 70;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int N_DIR          = 23;

  typedef logic [63:0]                 u64_t;
  typedef logic [mrr_pkg::FIELD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_PASS,
    CHK_FAIL
  } chk_t;

  typedef struct {
    word_t cand;
    word_t wit;
    chk_t  chk;
    bit    hold;
  } item_t;

  typedef struct {
    word_t cand;
    word_t wit;
    logic  prime;
  } verdict_t;

  localparam u64_t VAL_MASK = (u64_t'(1) << mrr_pkg::WIDTH) - 1;
  localparam word_t ONES    = {mrr_pkg::FIELD_W{1'b1}};

  localparam word_t BIG_PRIMES [4] = '{
    63'd9223372036854775783, 63'd2305843009213693951,
    63'd4611686018427387847, 63'd2147483647
  };
  localparam word_t PSEUDO [6] = '{
    63'd2047, 63'd1373653, 63'd25326001, 63'd3215031751,
    63'd561, 63'd3825123056546413051
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t candidate = '0;
  word_t witness = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  probably_prime;

  item_t    stim_q [$];
  verdict_t verdict_q [$];
  int       n_sent, n_results, n_prime, n_wide, errors, idle_run;

  // directed rows: extremes, trivial candidates, special witnesses, pseudoprimes
  item_t dir_rows [N_DIR] = '{
    '{63'd0, 63'd0, CHK_FAIL, 1'b0},
    '{63'd1, 63'd1, CHK_FAIL, 1'b0},
    '{63'd2, 63'd0, CHK_PASS, 1'b0},
    '{63'd2, ONES, CHK_PASS, 1'b0},
    '{63'd4, 63'd3, CHK_FAIL, 1'b0},
    '{ONES, ONES, CHK_FAIL, 1'b0},
    '{63'd3, 63'd0, CHK_FAIL, 1'b0},
    '{63'd3, 63'd1, CHK_PASS, 1'b0},
    '{63'd3, 63'd2, CHK_PASS, 1'b0},
    '{63'd561, 63'd1, CHK_PASS, 1'b0},
    '{63'd561, 63'd560, CHK_PASS, 1'b0},
    '{63'd561, 63'd2, CHK_MODEL, 1'b0},
    '{63'd2047, 63'd2, CHK_MODEL, 1'b0},
    '{63'd2047, 63'd3, CHK_MODEL, 1'b0},
    '{63'd2305843009213693951, 63'd3, CHK_MODEL, 1'b0},
    '{63'd9223372036854775783, 63'd2, CHK_MODEL, 1'b1},
    '{63'd9223372036854775783, ONES, CHK_MODEL, 1'b0},
    '{63'd4611686018427387905, 63'd3, CHK_MODEL, 1'b0},
    '{63'd4611686018427387904, 63'd7, CHK_FAIL, 1'b0},
    '{63'd3215031751, 63'd7, CHK_MODEL, 1'b0},
    '{63'd25, 63'd7, CHK_MODEL, 1'b0},
    '{63'd9, 63'd8, CHK_PASS, 1'b0},
    '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, CHK_MODEL, 1'b0}
  };

  miller_rabin_round dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .candidate      (candidate),
    .witness        (witness),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .probably_prime (probably_prime)
  );

  always #5 clk = ~clk;

  function automatic word_t rand_word();
    u64_t r;
    r = {$urandom, $urandom};
    return r[mrr_pkg::FIELD_W-1:0];
  endfunction

  function automatic u64_t shift_add_mulmod(u64_t x, u64_t y, u64_t m);
    u64_t acc, addend;
    acc = '0;
    addend = x;
    while (y != 0) begin
      if (y[0]) begin
        acc += addend;
        if (acc >= m) acc -= m;
      end
      addend <<= 1;
      if (addend >= m) addend -= m;
      y >>= 1;
    end
    return acc;
  endfunction

  function automatic logic round_verdict(word_t cand, word_t wit);
    u64_t n, d, x, b, sq;
    int   k, i;
    n = u64_t'(cand) & VAL_MASK;
    if (n == 2) return 1'b1;
    if (n < 2 || !n[0]) return 1'b0;
    d = n - 1;
    k = 0;
    while (!d[0]) begin
      d >>= 1;
      k++;
    end
    b = (u64_t'(wit) & VAL_MASK) % n;
    x = 1;
    while (d != 0) begin
      if (d[0]) x = shift_add_mulmod(x, b, n);
      b = shift_add_mulmod(b, b, n);
      d >>= 1;
    end
    sq = '0;
    for (i = 0; i < k; i++) begin
      sq = shift_add_mulmod(x, x, n);
      if (sq == 1 && x != 1 && x != n - 1) return 1'b0;
      x = sq;
    end
    return sq == 1;
  endfunction

  // mostly well-formed odd candidates, small so items stay short
  task automatic add_random_items();
    item_t it;
    word_t p;
    int unsigned f;
    bit ok;
    int i;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      it.chk  = CHK_MODEL;
      it.hold = (i == 0);
      it.wit  = rand_word();
      case ($urandom_range(15))
        0, 1, 2, 3, 4, 5: begin
          p = word_t'($urandom_range(1 << 20, 5) | 1);
          do begin
            ok = 1'b1;
            for (f = 3; f * f <= p && ok; f += 2)
              if (p % f == 0) ok = 1'b0;
            if (!ok) p += 2;
          end while (!ok);
          it.cand = p;
          if ($urandom_range(1)) it.wit = word_t'($urandom_range(int'(p) - 2, 2));
        end
        6, 7, 8: begin
          it.cand = word_t'(($urandom_range(511, 1) * 2 + 1) * ($urandom_range(511, 1) * 2 + 1));
        end
        9, 10: begin
          case ($urandom_range(3))
            0: it.cand = '0;
            1: it.cand = word_t'(1);
            2: it.cand = word_t'(2);
            default: it.cand = rand_word() & ~word_t'(1);
          endcase
        end
        11, 12: begin
          p = word_t'($urandom_range(1 << 16, 3) | 1);
          it.cand = p;
          case ($urandom_range(5))
            0: it.wit = '0;
            1: it.wit = word_t'(1);
            2: it.wit = p - 1;
            3: it.wit = p;
            4: it.wit = p * $urandom_range(1000, 2);
            default: it.wit = p + 1;
          endcase
        end
        13: begin
          it.cand = $urandom_range(1) ? (rand_word() | word_t'(1)) : rand_word();
        end
        14: begin
          it.cand = BIG_PRIMES[$urandom_range(3)];
        end
        default: begin
          it.cand = PSEUDO[$urandom_range(5)];
          if ($urandom_range(1)) it.wit = word_t'($urandom_range(13, 2));
        end
      endcase
      stim_q.push_back(it);
    end
  endtask

  always @(posedge clk) begin : chan_ctl
    logic took_in, took_out, calm, nxt_valid;
    item_t it;
    verdict_t v;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
      idle_run  = 0;
    end else begin
      took_out = out_valid && !out_stall;
      took_in  = in_valid && !in_stall;
      if (took_out) begin
        n_results++;
        if (probably_prime === 1'b1) n_prime++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, actual %0b",
                   $time, probably_prime);
        end else begin
          v = verdict_q.pop_front();
          if (probably_prime !== v.prime) begin
            errors++;
            $display("%0t: probably_prime for n=%0d a=%0d: expected %0b, actual %0b",
                     $time, v.cand, v.wit, v.prime, probably_prime);
          end
        end
      end
      if (took_in) begin
        it = stim_q.pop_front();
        v.cand  = it.cand;
        v.wit   = it.wit;
        v.prime = (it.chk == CHK_PASS) ? 1'b1 :
                  (it.chk == CHK_FAIL) ? 1'b0 : round_verdict(it.cand, it.wit);
        verdict_q.push_back(v);
        n_sent++;
        if (it.cand[mrr_pkg::FIELD_W-1]) n_wide++;
      end
      calm = n_sent >= CALM_FIRST && n_sent < CALM_LAST;
      if (!in_valid || took_in) begin
        nxt_valid = stim_q.size() != 0 && !(stim_q[0].hold && verdict_q.size() != 0) &&
                    (calm || $urandom_range(99) >= IDLE_PCT);
        in_valid <= nxt_valid;
        if (nxt_valid) begin
          candidate <= stim_q[0].cand;
          witness   <= stim_q[0].wit;
        end
      end
      out_stall <= !calm && $urandom_range(99) < IDLE_PCT;
      if (took_in || took_out) begin
        idle_run = 0;
      end else if (++idle_run >= WATCHDOG_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
                 $time, idle_run, verdict_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    foreach (dir_rows[i]) stim_q.push_back(dir_rows[i]);
    add_random_items();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d items (%0d directed), %0d with bit 62 of the candidate set",
             n_sent, N_DIR, n_wide);
    $display("checked %0d verdicts, %0d probable primes, %0d errors",
             n_results, n_prime, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
